>>> hw/rtl/gb5w_pkg.sv
// gb5w_pkg: shared types and constants for the 5x5 wrap-around Gaussian blur core.
// Request/result payload structs, register indexes, reset values, MAC datapath widths.
// No dependencies.
`timescale 1ns / 1ps

package gb5w_pkg;

    // request kinds
    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    // payload widths
    localparam int COORD_W = 5;
    localparam int PIX_W   = 16;
    localparam int WGT_W   = 16;
    localparam int DIM_W   = 6;
    localparam int PROD_W  = PIX_W + WGT_W + 1;   // signed pixel x unsigned weight
    localparam int ACC_W   = PROD_W + 5;          // 25 terms
    localparam int FRAC_W  = 16;                  // weights are 0.16
    // signed position arithmetic; holds -128 .. 127, enough for -2 .. 2*32
    localparam int POS_W   = 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH      = 3'd0,
        REG_FRAME_HEIGHT     = 3'd1,
        REG_WEIGHT_CENTER    = 3'd2,
        REG_WEIGHT_AXIS_NEAR = 3'd3,
        REG_WEIGHT_DIAG_NEAR = 3'd4,
        REG_WEIGHT_AXIS_FAR  = 3'd5,
        REG_WEIGHT_KNIGHT    = 3'd6,
        REG_WEIGHT_CORNER    = 3'd7
    } reg_idx_t;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH      = 6'd32;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT     = 6'd24;
    localparam logic [WGT_W-1:0] RST_WEIGHT_CENTER    = 16'd10624;
    localparam logic [WGT_W-1:0] RST_WEIGHT_AXIS_NEAR = 16'd6444;
    localparam logic [WGT_W-1:0] RST_WEIGHT_DIAG_NEAR = 16'd3908;
    localparam logic [WGT_W-1:0] RST_WEIGHT_AXIS_FAR  = 16'd1438;
    localparam logic [WGT_W-1:0] RST_WEIGHT_KNIGHT    = 16'd872;
    localparam logic [WGT_W-1:0] RST_WEIGHT_CORNER    = 16'd195;

    // tap counters run 0..4 for offsets -2..+2
    localparam logic [2:0] TAP_LAST   = 3'd4;
    localparam logic [2:0] TAP_CENTER = 3'd2;

    typedef struct packed {
        kind_t                     kind;
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        col;
        logic signed [PIX_W-1:0]   pixel;
    } in_req_t;

    typedef struct packed {
        logic signed [PIX_W-1:0]   filtered;
        logic [COORD_W-1:0]        out_row;
        logic [COORD_W-1:0]        out_col;
        logic                      out_of_range;
    } out_rsp_t;

    // sequencer controls for the shared multiply-accumulate unit
    typedef struct packed {
        logic clear;    // zero the accumulator
        logic mul_en;   // pixel/weight pair valid, capture product
        logic acc_en;   // product valid, add into accumulator
    } mac_ctrl_t;

    // |tap - 2| for a tap counter value 0..4
    function automatic logic [1:0] tap_abs(input logic [2:0] tap);
        logic [1:0] res;
        res = 2'd0;
        unique case (tap)
            3'd0, 3'd4: res = 2'd2;
            3'd1, 3'd3: res = 2'd1;
            3'd2:       res = 2'd0;
            default:    res = 2'd0;
        endcase
        return res;
    endfunction

endpackage

>>> hw/rtl/gb5w_ram.sv
// gb5w_ram: generic single-port RAM, one access per cycle, registered read data.
// Parameters set word width and depth. No dependencies.
`timescale 1ns / 1ps

module gb5w_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write, or read with the data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/gb5w_mac.sv
// gb5w_mac: shared multiply-accumulate unit with round-to-nearest and 16-bit saturation.
// Depends on gb5w_pkg (widths, mac_ctrl_t).
`timescale 1ns / 1ps

module gb5w_mac
    import gb5w_pkg::*;
(
    input  logic                    clk,
    input  mac_ctrl_t               ctrl,
    input  logic signed [PIX_W-1:0] pixel,
    input  logic [WGT_W-1:0]        weight,
    output logic signed [PIX_W-1:0] sum
);

    localparam int Q_W = ACC_W - FRAC_W;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [Q_W-1:0]    quot;

    // stage 1: product (signed pixel times unsigned weight)
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= PROD_W'(pixel * $signed({1'b0, weight}));
        end
    end

    // stage 2: accumulate
    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // add half, floor-divide by 2^16, clamp to signed 16 bits
    always_comb
    begin
        rounded = acc_reg + ACC_W'(signed'(1 <<< (FRAC_W - 1)));
        quot    = Q_W'(rounded >>> FRAC_W);
        priority if (quot > Q_W'(signed'(32767)))
        begin
            sum = 16'sh7FFF;
        end
        else if (quot < -Q_W'(signed'(32768)))
        begin
            sum = 16'sh8000;
        end
        else
        begin
            sum = PIX_W'(quot);
        end
    end

endmodule

>>> hw/rtl/gaussian_blur_5x5_wrap_core.sv
// gaussian_blur_5x5_wrap_core: frame store with 5x5 Gaussian query, toroidal edge wrap.
// Depends on gb5w_pkg, gb5w_ram (frame store) and gb5w_mac (shared multiply-accumulate).
`timescale 1ns / 1ps
//
//  Channel   Ports                          Handshake
//  ------    -----------------------------  -----------------------------------------
//  request   start, busy, request           taken when start = 1 and busy = 0
//  result    done, result                   valid for one cycle while done = 1
//  config    cfg_we, cfg_index, cfg_data    written when cfg_we = 1, no wait
//
//  A load is written when it is taken. A query inside the frame reads its 25 neighbours
//  one per cycle through the single frame-store port into one multiply-accumulate, so
//  busy stays high until the sum is ready and done follows on the next cycle. An
//  out-of-range request gives its result on the next cycle and leaves busy low.
//  Reset (rst_n low, asynchronous) restores the configuration and control registers;
//  store contents are undefined until written. The receiver cannot stall the result.

module gaussian_blur_5x5_wrap_core
    import gb5w_pkg::*;
#(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  in_req_t               request,
    output logic                  done,
    output out_rsp_t              result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [DIM_W-1:0]   width_cfg_reg, height_cfg_reg;
    logic [WGT_W-1:0]   w_center_reg, w_axis_near_reg, w_diag_near_reg;
    logic [WGT_W-1:0]   w_axis_far_reg, w_knight_reg, w_corner_reg;
    logic [COORD_W-1:0] row_reg, col_reg;
    logic [2:0]         dr_reg, dr_next, dc_reg, dc_next;
    logic               rd_vld_reg, prod_vld_reg;
    logic [WGT_W-1:0]   wsel_reg, wsel;
    logic               done_reg, done_next;
    out_rsp_t           result_reg, result_next;

    logic [POS_W-1:0]   w_eff, h_eff;
    logic               accept, outside;
    logic [POS_W-1:0]   tap_row, tap_col;
    logic [AW-1:0]      ram_addr;
    logic               ram_we;
    logic [PIX_W-1:0]   ram_rdata;
    mac_ctrl_t          mac_ctrl;
    logic signed [PIX_W-1:0] mac_sum;

    // effective frame size, clamped to [2, MAX]
    function automatic logic [POS_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [POS_W-1:0] hi);
        logic [POS_W-1:0] ext;
        ext = POS_W'(v);
        if (ext < POS_W'(2))
        begin
            return POS_W'(2);
        end
        if (ext > hi)
        begin
            return hi;
        end
        return ext;
    endfunction

    // centre coordinate plus tap offset, wrapped into [0, size)
    function automatic logic [POS_W-1:0] wrap_pos(input logic [COORD_W-1:0] base,
                                                  input logic [2:0] tap,
                                                  input logic [POS_W-1:0] size);
        logic signed [POS_W-1:0] pos;
        pos = signed'(POS_W'(base)) + signed'(POS_W'(tap)) - signed'(POS_W'(TAP_CENTER));
        if (pos < 0)
        begin
            pos = pos + signed'(size);
        end
        else if (pos >= signed'(size))
        begin
            pos = pos - signed'(size);
        end
        return POS_W'(pos);
    endfunction

    // row-major store address
    function automatic logic [AW-1:0] pix_addr(input logic [POS_W-1:0] r,
                                               input logic [POS_W-1:0] c);
        return AW'(r) * AW'(MAX_WIDTH) + AW'(c);
    endfunction

    assign w_eff   = clamp_dim(width_cfg_reg, POS_W'(MAX_WIDTH));
    assign h_eff   = clamp_dim(height_cfg_reg, POS_W'(MAX_HEIGHT));
    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign outside = (POS_W'(request.row) >= h_eff) || (POS_W'(request.col) >= w_eff);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg   <= RST_FRAME_WIDTH;
            height_cfg_reg  <= RST_FRAME_HEIGHT;
            w_center_reg    <= RST_WEIGHT_CENTER;
            w_axis_near_reg <= RST_WEIGHT_AXIS_NEAR;
            w_diag_near_reg <= RST_WEIGHT_DIAG_NEAR;
            w_axis_far_reg  <= RST_WEIGHT_AXIS_FAR;
            w_knight_reg    <= RST_WEIGHT_KNIGHT;
            w_corner_reg    <= RST_WEIGHT_CORNER;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_FRAME_WIDTH:      width_cfg_reg   <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT:     height_cfg_reg  <= cfg_data[DIM_W-1:0];
                REG_WEIGHT_CENTER:    w_center_reg    <= cfg_data;
                REG_WEIGHT_AXIS_NEAR: w_axis_near_reg <= cfg_data;
                REG_WEIGHT_DIAG_NEAR: w_diag_near_reg <= cfg_data;
                REG_WEIGHT_AXIS_FAR:  w_axis_far_reg  <= cfg_data;
                REG_WEIGHT_KNIGHT:    w_knight_reg    <= cfg_data;
                REG_WEIGHT_CORNER:    w_corner_reg    <= cfg_data;
                default:              ;
            endcase
        end
    end

    // tap address and weight
    assign tap_row = wrap_pos(row_reg, dr_reg, h_eff);
    assign tap_col = wrap_pos(col_reg, dc_reg, w_eff);

    always_comb
    begin
        unique case ({tap_abs(dr_reg), tap_abs(dc_reg)})
            4'b00_00:           wsel = w_center_reg;
            4'b00_01, 4'b01_00: wsel = w_axis_near_reg;
            4'b01_01:           wsel = w_diag_near_reg;
            4'b00_10, 4'b10_00: wsel = w_axis_far_reg;
            4'b01_10, 4'b10_01: wsel = w_knight_reg;
            4'b10_10:           wsel = w_corner_reg;
            default:            wsel = '0;
        endcase
    end

    // store port: request address when idle, tap address while running
    assign ram_we   = accept && (request.kind == KIND_LOAD) && !outside;
    assign ram_addr = busy ? pix_addr(tap_row, tap_col)
                           : pix_addr(POS_W'(request.row), POS_W'(request.col));

    gb5w_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (request.pixel),
        .rdata (ram_rdata)
    );

    assign mac_ctrl.clear  = accept && (request.kind == KIND_QUERY) && !outside;
    assign mac_ctrl.mul_en = rd_vld_reg;
    assign mac_ctrl.acc_en = prod_vld_reg;

    gb5w_mac u_mac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .pixel  (signed'(ram_rdata)),
        .weight (wsel_reg),
        .sum    (mac_sum)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        dr_next     = dr_reg;
        dc_next     = dc_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && outside)
                begin
                    done_next                = 1'b1;
                    result_next.filtered     = '0;
                    result_next.out_row      = request.row;
                    result_next.out_col      = request.col;
                    result_next.out_of_range = 1'b1;
                end
                else if (accept && (request.kind == KIND_QUERY))
                begin
                    state_next = ST_RUN;
                    dr_next    = '0;
                    dc_next    = '0;
                end
            end
            ST_RUN:
            begin
                if (dc_reg == TAP_LAST)
                begin
                    dc_next = '0;
                    dr_next = dr_reg + 3'd1;
                    if (dr_reg == TAP_LAST)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    dc_next = dc_reg + 3'd1;
                end
            end
            ST_DRAIN:
            begin
                // last product has been accumulated
                if (!rd_vld_reg && !prod_vld_reg)
                begin
                    state_next               = ST_IDLE;
                    done_next                = 1'b1;
                    result_next.filtered     = mac_sum;
                    result_next.out_row      = row_reg;
                    result_next.out_col      = col_reg;
                    result_next.out_of_range = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
            dr_reg       <= '0;
            dc_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_vld_reg   <= (state_reg == ST_RUN);
            prod_vld_reg <= rd_vld_reg;
            done_reg     <= done_next;
            dr_reg       <= dr_next;
            dc_reg       <= dc_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg <= request.row;
            col_reg <= request.col;
        end
        wsel_reg   <= wsel;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> verif/tb_gaussian_blur_5x5_wrap_core.sv
// tb_gaussian_blur_5x5_wrap_core: self-checking testbench for the 5x5 wrap-around Gaussian core.
// Drives load/query requests and register writes, predicts each result and compares it.
// Depends on gb5w_pkg and gaussian_blur_5x5_wrap_core.
`timescale 1ns / 1ps

module tb_gaussian_blur_5x5_wrap_core;
    import gb5w_pkg::*;

    localparam int MAX_W        = 32;
    localparam int MAX_H        = 32;
    localparam int DRAIN_CYCLES = 40;       // outlasts a query's busy stretch and its done
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 50;

    typedef enum int {
        WGT_RANDOM,
        WGT_MAX
    } wgt_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    in_req_t               request;
    logic                  done;
    out_rsp_t              result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state: register copy and frame store copy
    logic [15:0]        cfg_model [8];
    logic signed [15:0] pixel_mem [MAX_W*MAX_H];
    out_rsp_t           expected_rsp [$];

    int err_count  = 0;
    int idle_pct   = 20;
    int cycle_count = 0;

    gaussian_blur_5x5_wrap_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_gaussian_blur_5x5_wrap_core failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // frame size register clamped to [2, max]
    function automatic int eff_dim(logic [15:0] v, int hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return int'(v);
    endfunction

    // kernel weight picked by absolute row/column offset
    function automatic logic [15:0] tap_weight(int ar, int ac);
        reg_idx_t idx;
        if (ar == 2 && ac == 2)
            idx = REG_WEIGHT_CORNER;
        else if (ar + ac == 3)
            idx = REG_WEIGHT_KNIGHT;
        else if (ar + ac == 2 && ar != ac)
            idx = REG_WEIGHT_AXIS_FAR;
        else if (ar == 1 && ac == 1)
            idx = REG_WEIGHT_DIAG_NEAR;
        else if (ar + ac == 1)
            idx = REG_WEIGHT_AXIS_NEAR;
        else
            idx = REG_WEIGHT_CENTER;
        return cfg_model[idx];
    endfunction

    // exact 25-tap sum, round half up, saturate to 16 bits
    function automatic logic signed [15:0] blur_value(int r, int c, int w, int h);
        longint acc;
        longint q;
        int     rr;
        int     cc;
        acc = 0;
        for (int dr = -2; dr <= 2; dr++)
        begin
            for (int dc = -2; dc <= 2; dc++)
            begin
                rr = r + dr;
                cc = c + dc;
                if (rr < 0)
                    rr += h;
                else if (rr >= h)
                    rr -= h;
                if (cc < 0)
                    cc += w;
                else if (cc >= w)
                    cc -= w;
                acc += longint'(pixel_mem[rr*MAX_W + cc]) *
                       longint'(tap_weight(dr < 0 ? -dr : dr, dc < 0 ? -dc : dc));
            end
        end
        q = (acc + 32768) >>> 16;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    // update the store copy or queue the expected result for one accepted request
    task automatic predict_request(in_req_t req);
        int       w;
        int       h;
        bit       outside;
        out_rsp_t rsp;
        w = eff_dim(cfg_model[REG_FRAME_WIDTH], MAX_W);
        h = eff_dim(cfg_model[REG_FRAME_HEIGHT], MAX_H);
        outside = (req.row >= h) || (req.col >= w);
        if (req.kind == KIND_LOAD && !outside)
            pixel_mem[req.row*MAX_W + req.col] = req.pixel;
        else
        begin
            rsp.filtered     = outside ? '0 : blur_value(req.row, req.col, w, h);
            rsp.out_row      = req.row;
            rsp.out_col      = req.col;
            rsp.out_of_range = outside;
            expected_rsp.push_back(rsp);
        end
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_result(out_rsp_t got);
        out_rsp_t want;
        if (expected_rsp.size() == 0)
            report_mismatch("result with nothing pending", got.out_row, -1);
        else
        begin
            want = expected_rsp.pop_front();
            if (got.filtered !== want.filtered)
                report_mismatch("filtered", int'(got.filtered), int'(want.filtered));
            if (got.out_row !== want.out_row)
                report_mismatch("out_row", got.out_row, want.out_row);
            if (got.out_col !== want.out_col)
                report_mismatch("out_col", got.out_col, want.out_col);
            if (got.out_of_range !== want.out_of_range)
                report_mismatch("out_of_range", got.out_of_range, want.out_of_range);
        end
    endtask

    // sample at the edge that ends the done cycle
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            check_result(result);
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one request; start is left high so back-to-back requests need no gap
    task automatic send_request(kind_t kind, int row, int col, logic [15:0] pix);
        in_req_t req;
        req.kind  = kind;
        req.row   = row[COORD_W-1:0];
        req.col   = col[COORD_W-1:0];
        req.pixel = pix;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_request(req);
    endtask

    // wait for every pending result, then let a trailing load settle
    task automatic drain_results();
        start <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all eight registers in index order
    task automatic apply_setting(logic [15:0] w, logic [15:0] h, logic [15:0] wc,
                                 logic [15:0] wan, logic [15:0] wdn, logic [15:0] waf,
                                 logic [15:0] wk, logic [15:0] wcr);
        logic [15:0] vals [8];
        vals = '{w, h, wc, wan, wdn, waf, wk, wcr};
        cfg_we <= 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            cfg_index <= reg_idx_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            if (i == REG_FRAME_WIDTH || i == REG_FRAME_HEIGHT)
                cfg_model[i] = vals[i] & 16'h003F;
            else
                cfg_model[i] = vals[i];
        end
        cfg_we <= 1'b0;
    endtask

    task automatic apply_default_weights(logic [15:0] w, logic [15:0] h);
        apply_setting(w, h, RST_WEIGHT_CENTER, RST_WEIGHT_AXIS_NEAR, RST_WEIGHT_DIAG_NEAR,
                      RST_WEIGHT_AXIS_FAR, RST_WEIGHT_KNIGHT, RST_WEIGHT_CORNER);
    endtask

    // mostly random samples, with the extremes now and then
    function automatic logic [15:0] rand_pixel();
        logic [15:0] v;
        case ($urandom_range(9))
            0: v = 16'h7FFF;
            1: v = 16'h8000;
            default: v = 16'($urandom_range(65535));
        endcase
        return v;
    endfunction

    // load whole rows; a full-scale positive block at the origin and a
    // full-scale negative block at (10..14, 10..14) feed the saturation checks
    task automatic load_rows(int first, int last);
        logic [15:0] pix;
        for (int r = first; r <= last; r++)
        begin
            for (int c = 0; c < MAX_W; c++)
            begin
                if (r <= 4 && c <= 4)
                    pix = 16'h7FFF;
                else if (r >= 10 && r <= 14 && c >= 10 && c <= 14)
                    pix = 16'h8000;
                else
                    pix = rand_pixel();
                send_request(KIND_LOAD, r, c, pix);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset frame is 32x24: rows 24..31 are flagged; then queries with reset weights
    task automatic test_reset_config();
        load_rows(0, MAX_H - 1);
        send_request(KIND_QUERY, 0, 0, 16'h0000);
        send_request(KIND_QUERY, 23, 31, 16'hFFFF);
        send_request(KIND_QUERY, 12, 7, 16'h5A5A);
        drain_results();
        // open the full frame and fill the rows that were out of range
        apply_default_weights(16'd32, 16'd32);
        load_rows(24, MAX_H - 1);
    endtask

    task automatic test_out_of_range();
        drain_results();
        apply_default_weights(16'd5, 16'd7);
        send_request(KIND_QUERY, 0, 5, 16'h0000);
        send_request(KIND_LOAD, 7, 0, 16'h1234);
        send_request(KIND_QUERY, 31, 31, 16'h0000);
        send_request(KIND_LOAD, 6, 4, 16'h8000);
        send_request(KIND_QUERY, 6, 4, 16'h0000);
    endtask

    // center weight 0.5 only: odd samples land exactly on a half
    task automatic test_rounding_ties();
        drain_results();
        apply_setting(16'd32, 16'd32, 16'h8000, '0, '0, '0, '0, '0);
        send_request(KIND_LOAD, 20, 20, 16'd1);
        send_request(KIND_QUERY, 20, 20, 16'h0000);
        send_request(KIND_LOAD, 20, 20, 16'hFFFF);
        send_request(KIND_QUERY, 20, 20, 16'h0000);
        send_request(KIND_LOAD, 20, 20, 16'd3);
        send_request(KIND_QUERY, 20, 20, 16'h0000);
        send_request(KIND_LOAD, 20, 20, 16'hFFFD);
        send_request(KIND_QUERY, 20, 20, 16'h0000);
    endtask

    task automatic test_saturation();
        drain_results();
        apply_setting(16'd32, 16'd32, '1, '1, '1, '1, '1, '1);
        send_request(KIND_QUERY, 2, 2, 16'h0000);
        send_request(KIND_QUERY, 12, 12, 16'h0000);
    endtask

    task automatic test_zero_weights();
        drain_results();
        apply_setting(16'd32, 16'd32, '0, '0, '0, '0, '0, '0);
        send_request(KIND_QUERY, 7, 9, 16'h0000);
    endtask

    // corners pull neighbors from the opposite edges
    task automatic test_edge_wrap();
        drain_results();
        apply_default_weights(16'd32, 16'd32);
        send_request(KIND_QUERY, 0, 0, 16'h0000);
        send_request(KIND_QUERY, 0, 31, 16'h0000);
        send_request(KIND_QUERY, 31, 0, 16'h0000);
        send_request(KIND_QUERY, 31, 31, 16'h0000);
    endtask

    // one setting, then a random mix of loads and queries
    task automatic run_traffic(int count, logic [15:0] w, logic [15:0] h,
                               wgt_mode_t mode, int idle);
        logic [15:0] wv [6];
        int          we;
        int          he;
        int          row;
        int          col;
        drain_results();
        for (int i = 0; i < 6; i++)
            wv[i] = (mode == WGT_MAX) ? 16'hFFFF : 16'($urandom_range(65535));
        apply_setting(w, h, wv[0], wv[1], wv[2], wv[3], wv[4], wv[5]);
        idle_pct = idle;
        we = eff_dim(cfg_model[REG_FRAME_WIDTH], MAX_W);
        he = eff_dim(cfg_model[REG_FRAME_HEIGHT], MAX_H);
        repeat (count)
        begin
            if ($urandom_range(99) < 85)
            begin
                row = $urandom_range(he - 1);
                col = $urandom_range(we - 1);
            end
            else
            begin
                row = $urandom_range(MAX_H - 1);
                col = $urandom_range(MAX_W - 1);
            end
            send_request(kind_t'($urandom_range(1)), row, col, rand_pixel());
        end
        idle_pct = 20;
    endtask

    task automatic test_random_traffic();
        run_traffic(60, 16'd32, 16'd32, WGT_RANDOM, 20);
        // width 0 and height 1 both clamp to 2
        run_traffic(40, 16'd0, 16'd1, WGT_RANDOM, 20);
        // upper bits dropped: width 63 clamps to 32
        run_traffic(40, 16'hFFFF, 16'd2, WGT_MAX, 20);
        // long stretch with no gaps
        run_traffic(80, 16'($urandom_range(2, 32)), 16'($urandom_range(2, 32)),
                    WGT_RANDOM, 0);
        run_traffic(40, 16'd3, 16'd31, WGT_RANDOM, 20);
        run_traffic(40, 16'd32, 16'd24, WGT_RANDOM, 20);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        request   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        cfg_model[REG_FRAME_WIDTH]      = RST_FRAME_WIDTH;
        cfg_model[REG_FRAME_HEIGHT]     = RST_FRAME_HEIGHT;
        cfg_model[REG_WEIGHT_CENTER]    = RST_WEIGHT_CENTER;
        cfg_model[REG_WEIGHT_AXIS_NEAR] = RST_WEIGHT_AXIS_NEAR;
        cfg_model[REG_WEIGHT_DIAG_NEAR] = RST_WEIGHT_DIAG_NEAR;
        cfg_model[REG_WEIGHT_AXIS_FAR]  = RST_WEIGHT_AXIS_FAR;
        cfg_model[REG_WEIGHT_KNIGHT]    = RST_WEIGHT_KNIGHT;
        cfg_model[REG_WEIGHT_CORNER]    = RST_WEIGHT_CORNER;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_out_of_range();
        test_rounding_ties();
        test_saturation();
        test_zero_weights();
        test_edge_wrap();
        test_random_traffic();
        drain_results();

        if (err_count == 0)
            $display("tb_gaussian_blur_5x5_wrap_core passed");
        else
            $display("tb_gaussian_blur_5x5_wrap_core failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/gb5w_pkg.sv
hw/rtl/gb5w_ram.sv
hw/rtl/gb5w_mac.sv
hw/rtl/gaussian_blur_5x5_wrap_core.sv
verif/tb_gaussian_blur_5x5_wrap_core.sv
